>>> rtl/core/acl_pkg.sv
// Shared types and constants for the IPv4 first-match access list.
package acl_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ADDR_W      = 32;
    localparam int PLEN_W      = 6;
    localparam int TAG_W       = 8;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int BIT_W       = $clog2(ADDR_W);

    localparam logic [1:0] OP_INS_PREFIX = 2'd0;
    localparam logic [1:0] OP_INS_RANGE  = 2'd1;
    localparam logic [1:0] OP_LOOKUP     = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_PFX_LONG   = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] range_end;
        logic [PLEN_W-1:0] prefix_length;
        logic [TAG_W-1:0]  entry_tag;
        logic              address_present;
    } t_req;

    typedef struct packed {
        logic             decision;
        logic             matched;
        logic [TAG_W-1:0] matched_tag;
        logic [1:0]       status;
    } t_rsp;

endpackage

>>> rtl/core/ipv4_acl_first_match_top.sv
// Top level of the IPv4 first-match access list, bit-serial compare lanes.
//
//  channel   | ports                         | handshake
//  ----------+-------------------------------+------------------------------------
//  request   | i_req                         | start & !busy
//  result    | o_rsp                         | o_rsp_vld, one cycle, no stall
//  config    | i_cfg_wdata (default verdict) | i_cfg_we, no wait
//
// Every request occupies the block through the SHIFT and DONE states: the 32-bit address
// is compared MSB first, one bit per cycle, against all entries in parallel lanes, then
// the DONE state resolves priority and writes the table; the result strobe is registered
// from DONE. busy drops in the cycle the result is shown, so the next request can be
// accepted at the edge that ends the strobe.
// Synchronous active-low reset clears the entry count, FSM and default verdict
// (allow); entry storage is not reset. The receiver cannot stall results.
module ipv4_acl_first_match_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  acl_pkg::t_req i_req,
    output logic          o_rsp_vld,
    output acl_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata
);
    import acl_pkg::*;

    t_state r_state, n_state;
    logic   accept;
    logic   shift_en;
    logic   done_en;

    logic [BIT_W-1:0] r_bit;
    logic [CNT_W-1:0] r_count;
    logic             r_dflt;

    // latched request, address fields rotate once per bit
    logic [1:0]        r_op;
    logic [ADDR_W-1:0] r_a;
    logic [ADDR_W-1:0] r_b;
    logic [PLEN_W-1:0] r_plen;
    logic [TAG_W-1:0]  r_tag_in;
    logic              r_present;

    // serial compare of address vs range_end for range inserts
    logic r_ab_dec;
    logic r_a_lt;

    // entry table
    logic [ADDR_W-1:0] r_start [MAX_ENTRIES];
    logic [ADDR_W-1:0] r_end   [MAX_ENTRIES];
    logic [PLEN_W-1:0] r_pfx   [MAX_ENTRIES];
    logic              r_rng   [MAX_ENTRIES];
    logic [TAG_W-1:0]  r_tag   [MAX_ENTRIES];

    // per-lane compare flags
    logic [MAX_ENTRIES-1:0] r_lo_dec, r_lo_less;
    logic [MAX_ENTRIES-1:0] r_hi_dec, r_hi_greater;
    logic [MAX_ENTRIES-1:0] r_pfx_ok;

    logic [MAX_ENTRIES-1:0] hit;
    logic                   any_hit;
    logic [TAG_W-1:0]       hit_tag;
    logic                   a_lt_b;
    logic                   full;
    logic                   pfx_bad;
    logic                   do_write;
    t_rsp                   n_rsp;

    assign accept = start && !busy;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_SHIFT;
            S_SHIFT: if (r_bit == BIT_W'(ADDR_W - 1)) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        busy     = 1'b0;
        shift_en = 1'b0;
        done_en  = 1'b0;
        case (r_state)
            S_IDLE:  busy = 1'b0;
            S_SHIFT: begin
                busy     = 1'b1;
                shift_en = 1'b1;
            end
            S_DONE: begin
                busy    = 1'b1;
                done_en = 1'b1;
            end
            default: busy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bit     <= '0;
            r_count   <= '0;
            r_dflt    <= 1'b1;
            o_rsp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            o_rsp_vld <= done_en;
            if (i_cfg_we) r_dflt <= i_cfg_wdata;
            if (accept) r_bit <= '0;
            else if (shift_en) r_bit <= r_bit + BIT_W'(1);
            if (do_write) r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_en) o_rsp <= n_rsp;
    end

    // request shift registers and lane flags
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op         <= i_req.operation;
            r_a          <= i_req.address;
            r_b          <= i_req.range_end;
            r_plen       <= i_req.prefix_length;
            r_tag_in     <= i_req.entry_tag;
            r_present    <= i_req.address_present;
            r_ab_dec     <= 1'b0;
            r_a_lt       <= 1'b0;
            r_lo_dec     <= '0;
            r_lo_less    <= '0;
            r_hi_dec     <= '0;
            r_hi_greater <= '0;
            r_pfx_ok     <= '1;
        end else if (shift_en) begin
            r_a <= {r_a[ADDR_W-2:0], r_a[ADDR_W-1]};
            r_b <= {r_b[ADDR_W-2:0], r_b[ADDR_W-1]};
            if (!r_ab_dec && (r_a[ADDR_W-1] != r_b[ADDR_W-1])) begin
                r_ab_dec <= 1'b1;
                r_a_lt   <= !r_a[ADDR_W-1];
            end
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (!r_lo_dec[i] && (r_a[ADDR_W-1] != r_start[i][ADDR_W-1])) begin
                    r_lo_dec[i]  <= 1'b1;
                    r_lo_less[i] <= !r_a[ADDR_W-1];
                end
                if (!r_hi_dec[i] && (r_a[ADDR_W-1] != r_end[i][ADDR_W-1])) begin
                    r_hi_dec[i]     <= 1'b1;
                    r_hi_greater[i] <= r_a[ADDR_W-1];
                end
                // only bits inside the prefix count
                if (({1'b0, r_bit} < r_pfx[i]) &&
                    (r_a[ADDR_W-1] != r_start[i][ADDR_W-1])) begin
                    r_pfx_ok[i] <= 1'b0;
                end
            end
        end
    end

    // entry storage: rotates during compare, written on a good insert
    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_start[i] <= {r_start[i][ADDR_W-2:0], r_start[i][ADDR_W-1]};
                r_end[i]   <= {r_end[i][ADDR_W-2:0], r_end[i][ADDR_W-1]};
            end
        end else if (do_write) begin
            r_tag[r_count[IDX_W-1:0]] <= r_tag_in;
            if (r_op == OP_INS_PREFIX) begin
                r_rng[r_count[IDX_W-1:0]]   <= 1'b0;
                r_start[r_count[IDX_W-1:0]] <= r_a;
                r_end[r_count[IDX_W-1:0]]   <= '0;
                r_pfx[r_count[IDX_W-1:0]]   <= r_plen;
            end else begin
                r_rng[r_count[IDX_W-1:0]]   <= 1'b1;
                r_start[r_count[IDX_W-1:0]] <= a_lt_b ? r_a : r_b;
                r_end[r_count[IDX_W-1:0]]   <= a_lt_b ? r_b : r_a;
                r_pfx[r_count[IDX_W-1:0]]   <= '0;
            end
        end
    end

    assign a_lt_b   = r_ab_dec && r_a_lt;
    assign full     = (r_count == CNT_W'(MAX_ENTRIES));
    assign pfx_bad  = (r_op == OP_INS_PREFIX) && (r_plen > PLEN_W'(ADDR_W));
    assign do_write = done_en && ((r_op == OP_INS_PREFIX) || (r_op == OP_INS_RANGE))
                      && !full && !pfx_bad;

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            hit[i] = (CNT_W'(i) < r_count) &&
                     (r_rng[i] ? (!r_lo_less[i] && !r_hi_greater[i]) : r_pfx_ok[i]);
        end
    end

    // lowest lane wins
    always_comb begin
        hit_tag = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (hit[i]) hit_tag = r_tag[i];
        end
    end

    assign any_hit = r_present && (hit != '0);

    always_comb begin
        n_rsp = '0;
        case (r_op)
            OP_INS_PREFIX, OP_INS_RANGE: begin
                if (full)         n_rsp.status = ST_FULL;
                else if (pfx_bad) n_rsp.status = ST_PFX_LONG;
                else              n_rsp.status = ST_OK;
            end
            OP_LOOKUP: begin
                if (r_count == '0) begin
                    n_rsp.decision = 1'b1;
                end else if (any_hit) begin
                    n_rsp.decision    = 1'b1;
                    n_rsp.matched     = 1'b1;
                    n_rsp.matched_tag = hit_tag;
                end else begin
                    n_rsp.decision = r_dflt;
                end
            end
            default: n_rsp = '0;
        endcase
    end

    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_vld |=> !o_rsp_vld)
        else $error("result strobe held for more than one cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy && !o_rsp_vld)
        else $error("accepted request did not start work");

    a_refused_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_vld && (o_rsp.status != ST_OK)) |-> (r_count == $past(r_count)))
        else $error("refused insert changed entry count");

    a_match_allows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_vld && o_rsp.matched) |-> (o_rsp.decision && (o_rsp.status == ST_OK)))
        else $error("matched lookup without allow");

endmodule

>>> tb/acl_verdict_monitor.sv
// Passive monitor for the IPv4 access list: predicts each response and checks the result strobe.
module acl_verdict_monitor
    import acl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic busy,
    input  t_req i_req,
    input  logic o_rsp_vld,
    input  t_rsp o_rsp,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_checked,
    output int   o_hits,
    output int   o_entries
);

    logic              default_allow;
    int                n_entries;
    logic              ent_range [MAX_ENTRIES];
    logic [ADDR_W-1:0] ent_lo    [MAX_ENTRIES];
    logic [ADDR_W-1:0] ent_hi    [MAX_ENTRIES];
    logic [PLEN_W-1:0] ent_plen  [MAX_ENTRIES];
    logic [TAG_W-1:0]  ent_tag   [MAX_ENTRIES];
    t_rsp              verdict_q [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
                 o_checked, what, got, want);
        o_mismatches++;
    endtask

    // Applies one request to the shadow table and returns the response it should produce.
    function automatic t_rsp apply_request(input t_req r);
        t_rsp              a;
        logic [ADDR_W-1:0] mask;
        bit                hit;
        a = '0;
        case (r.operation)
            OP_INS_PREFIX, OP_INS_RANGE: begin
                // full check wins over the prefix length check
                if (n_entries >= MAX_ENTRIES) begin
                    a.status = ST_FULL;
                end else if (r.operation == OP_INS_PREFIX && r.prefix_length > ADDR_W) begin
                    a.status = ST_PFX_LONG;
                end else begin
                    a.status             = ST_OK;
                    ent_tag[n_entries]   = r.entry_tag;
                    ent_range[n_entries] = (r.operation == OP_INS_RANGE);
                    ent_plen[n_entries]  = r.prefix_length;
                    if (r.operation == OP_INS_RANGE && r.range_end < r.address) begin
                        ent_lo[n_entries] = r.range_end;
                        ent_hi[n_entries] = r.address;
                    end else begin
                        ent_lo[n_entries] = r.address;
                        ent_hi[n_entries] = r.range_end;
                    end
                    n_entries++;
                end
            end
            OP_LOOKUP: begin
                if (n_entries == 0) begin
                    a.decision = 1'b1;      // empty list lets everything through
                end else begin
                    a.decision = default_allow;
                    if (r.address_present) begin
                        for (int i = 0; i < n_entries && !a.matched; i++) begin
                            if (ent_range[i]) begin
                                hit = (r.address >= ent_lo[i]) && (r.address <= ent_hi[i]);
                            end else begin
                                mask = (ent_plen[i] == 0) ? '0 :
                                       {ADDR_W{1'b1}} << (ADDR_W - ent_plen[i]);
                                hit  = ((r.address ^ ent_lo[i]) & mask) == '0;
                            end
                            if (hit) begin
                                a.decision    = 1'b1;
                                a.matched     = 1'b1;
                                a.matched_tag = ent_tag[i];
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            default_allow = 1'b1;
            n_entries     = 0;
            o_mismatches  = 0;
            o_checked     = 0;
            o_hits        = 0;
            verdict_q.delete();
        end else begin
            if (i_cfg_we) begin
                default_allow = i_cfg_wdata;
            end
            if (o_rsp_vld) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("result strobe with no request pending", int'(o_rsp), 0);
                end else begin
                    want = verdict_q.pop_front();
                    if (o_rsp.decision !== want.decision)
                        report_mismatch("decision", int'(o_rsp.decision),
                                        int'(want.decision));
                    if (o_rsp.matched !== want.matched)
                        report_mismatch("matched", int'(o_rsp.matched), int'(want.matched));
                    if (o_rsp.matched_tag !== want.matched_tag)
                        report_mismatch("matched_tag", int'(o_rsp.matched_tag),
                                        int'(want.matched_tag));
                    if (o_rsp.status !== want.status)
                        report_mismatch("status", int'(o_rsp.status), int'(want.status));
                end
                o_checked++;
            end
            if (start && !busy) begin
                want = apply_request(i_req);
                if (want.matched) o_hits++;
                verdict_q.push_back(want);
            end
        end
        o_pending = verdict_q.size();
        o_entries = n_entries;
    end

endmodule

>>> tb/testbench.sv
// Top of the access list testbench: clock, reset, request stimulus and final verdict.
module testbench;
    import acl_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         DRAIN_TAIL  = 40;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    t_req req;
    logic rsp_vld;
    t_rsp rsp;
    logic cfg_we;
    logic cfg_wdata;

    int mismatches;
    int pending;
    int checked;
    int hits;
    int entries;

    int                cycles;
    int                items_sent;
    int                burst_left;
    int                n_tbl;
    logic [ADDR_W-1:0] hint_q [$];

    ipv4_acl_first_match_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (req),
        .o_rsp_vld   (rsp_vld),
        .o_rsp       (rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    acl_verdict_monitor mon (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (req),
        .o_rsp_vld    (rsp_vld),
        .o_rsp        (rsp),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits),
        .o_entries    (entries)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still owed", cycles, pending);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_req random_fields();
        t_req r;
        r.operation       = 2'($urandom_range(0, 3));
        r.address         = $urandom;
        r.range_end       = $urandom;
        r.prefix_length   = PLEN_W'($urandom_range(0, 63));
        r.entry_tag       = TAG_W'($urandom_range(0, 255));
        r.address_present = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic t_req mk_req(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                                    input logic [ADDR_W-1:0] rend, input logic [PLEN_W-1:0] plen,
                                    input logic [TAG_W-1:0] tag, input logic present);
        t_req r;
        r.operation       = op;
        r.address         = addr;
        r.range_end       = rend;
        r.prefix_length   = plen;
        r.entry_tag       = tag;
        r.address_present = present;
        return r;
    endfunction

    // Holds the request until accepted, then either keeps the burst going or idles a while.
    task automatic send_request(input t_req r);
        int gap;
        @(negedge clk);
        start = 1'b1;
        req   = r;
        do @(posedge clk); while (busy);
        items_sent++;
        if (n_tbl < MAX_ENTRIES && (r.operation == OP_INS_RANGE ||
            (r.operation == OP_INS_PREFIX && r.prefix_length <= ADDR_W)))
            n_tbl++;
        burst_left--;
        if (burst_left <= 0) begin
            // gaps up to past the job length so start rises at every point of the compare
            gap = $urandom_range(1, 50);
            @(negedge clk);
            start = 1'b0;
            req   = random_fields();
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0 || busy) @(negedge clk);
    endtask

    task automatic write_default(input logic allow);
        wait_idle();
        cfg_we    = 1'b1;
        cfg_wdata = allow;
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_wdata = 1'($urandom_range(0, 1));
    endtask

    // Builds a well-formed insert and remembers addresses on and around its edges.
    task automatic make_entry(output t_req r, input bit catch_all);
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W:0]   top;
        logic [63:0]       off;
        int                len;
        r = random_fields();
        if (catch_all) begin
            r.operation     = OP_INS_PREFIX;
            r.prefix_length = '0;
        end else if ($urandom_range(0, 1)) begin
            len             = $urandom_range(1, 32);
            mask            = {ADDR_W{1'b1}} << (ADDR_W - len);
            r.operation     = OP_INS_PREFIX;
            r.prefix_length = PLEN_W'(len);
            hint_q.push_back(r.address);
            hint_q.push_back((r.address & mask) | ($urandom & ~mask));
            hint_q.push_back(r.address ^ (32'h1 << (ADDR_W - len)));
        end else begin
            lo = $urandom;
            case ($urandom_range(0, 2))
                0:       top = {1'b0, lo};
                1:       top = {1'b0, lo} + $urandom_range(0, 65535);
                default: top = {1'b0, lo} + $urandom;
            endcase
            hi = top[ADDR_W] ? '1 : top[ADDR_W-1:0];
            if ($urandom_range(0, 7) == 0) hi = '1;
            r.operation = OP_INS_RANGE;
            if ($urandom_range(0, 1)) begin
                r.address   = hi;
                r.range_end = lo;
            end else begin
                r.address   = lo;
                r.range_end = hi;
            end
            off = {32'h0, $urandom} % ({32'h0, hi} - {32'h0, lo} + 64'd1);
            hint_q.push_back(lo);
            hint_q.push_back(hi);
            hint_q.push_back(lo - 1);
            hint_q.push_back(hi + 1);
            hint_q.push_back(lo + off[ADDR_W-1:0]);
        end
    endtask

    task automatic next_request(output t_req r, input int insert_odds);
        int roll;
        int pick;
        r    = random_fields();
        roll = $urandom_range(0, 99);
        if (n_tbl < MAX_ENTRIES - 1 && $urandom_range(1, insert_odds) == 1) begin
            make_entry(r, 1'b0);
        end else if (roll < 6) begin
            r.operation     = OP_INS_PREFIX;
            r.prefix_length = PLEN_W'($urandom_range(33, 63));
        end else if (roll < 9) begin
            r.operation = OP_UNUSED;
        end else if (roll < 13 && n_tbl == MAX_ENTRIES) begin
            r.operation = $urandom_range(0, 1) ? OP_INS_RANGE : OP_INS_PREFIX;
        end else begin
            r.operation       = OP_LOOKUP;
            r.address_present = ($urandom_range(0, 9) != 0);
            pick              = $urandom_range(0, 9);
            if (pick < 6 && hint_q.size() > 0)
                r.address = hint_q[$urandom_range(0, hint_q.size()-1)];
            else if (pick == 6)
                r.address = '0;
            else if (pick == 7)
                r.address = '1;
        end
    endtask

    task automatic run_items(input int count, input int insert_odds);
        t_req r;
        repeat (count) begin
            next_request(r, insert_odds);
            send_request(r);
        end
    endtask

    initial begin
        t_req r;
        rst_n      = 1'b0;
        start      = 1'b0;
        req        = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = 1'b0;
        items_sent = 0;
        n_tbl      = 0;
        burst_left = $urandom_range(1, 8);
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty list ignores the deny default, bad inserts, overlap priority
        write_default(1'b0);
        send_request(mk_req(OP_LOOKUP,     32'h0A00_0001, '1,            6'd32, 8'hFF, 1'b1));
        send_request(mk_req(OP_LOOKUP,     '1,            '0,            6'd0,  8'h00, 1'b0));
        send_request(mk_req(OP_UNUSED,     '1,            '1,            6'd63, 8'hFF, 1'b1));
        send_request(mk_req(OP_INS_PREFIX, 32'hC0A8_0000, '0,            6'd33, 8'h11, 1'b1));
        send_request(mk_req(OP_INS_PREFIX, '1,            '1,            6'd63, 8'hFF, 1'b0));
        send_request(mk_req(OP_LOOKUP,     32'hC0A8_0001, '0,            6'd0,  8'h00, 1'b1));
        send_request(mk_req(OP_INS_PREFIX, '1,            '0,            6'd32, 8'hFF, 1'b0));
        send_request(mk_req(OP_INS_RANGE,  32'h0000_0010, '0,            6'd0,  8'h00, 1'b0));
        send_request(mk_req(OP_INS_PREFIX, 32'h0A12_3456, '1,            6'd8,  8'h0A, 1'b1));
        send_request(mk_req(OP_INS_RANGE,  '1,            32'hFFFF_FF00, 6'd63, 8'h55, 1'b1));
        send_request(mk_req(OP_LOOKUP,     '1,            '0,            6'd0,  8'h00, 1'b1));
        send_request(mk_req(OP_LOOKUP,     '0,            '1,            6'd63, 8'hFF, 1'b1));
        send_request(mk_req(OP_LOOKUP,     32'h0000_0010, '0,            6'd0,  8'h00, 1'b1));
        send_request(mk_req(OP_LOOKUP,     32'h0000_0011, '0,            6'd0,  8'h00, 1'b1));
        send_request(mk_req(OP_LOOKUP,     32'h0AFF_FFFF, '0,            6'd0,  8'h00, 1'b1));
        send_request(mk_req(OP_LOOKUP,     32'h0B00_0000, '0,            6'd0,  8'h00, 1'b1));
        send_request(mk_req(OP_LOOKUP,     32'hFFFF_FF80, '0,            6'd0,  8'h00, 1'b1));
        send_request(mk_req(OP_LOOKUP,     32'hFFFF_FEFF, '0,            6'd0,  8'h00, 1'b1));
        send_request(mk_req(OP_LOOKUP,     '0,            '0,            6'd0,  8'h00, 1'b0));
        send_request(mk_req(OP_UNUSED,     '0,            '0,            6'd0,  8'h00, 1'b0));
        hint_q = '{32'hFFFF_FFFF, 32'h0, 32'h10, 32'h11, 32'h0A00_0000, 32'h0B00_0000,
                   32'hFFFF_FF00, 32'hFFFF_FEFF};

        // partial tables under both defaults, growing slowly
        write_default(1'b1);
        run_items(600, 80);
        write_default(1'b0);
        run_items(450, 80);

        // fill up, closing with a /0 entry that catches every present address
        while (n_tbl < MAX_ENTRIES - 1) begin
            make_entry(r, 1'b0);
            send_request(r);
        end
        make_entry(r, 1'b1);
        send_request(r);
        send_request(mk_req(OP_INS_PREFIX, $urandom, $urandom, 6'd40, 8'h77, 1'b1));
        send_request(mk_req(OP_INS_PREFIX, $urandom, $urandom, 6'd8,  8'h78, 1'b1));
        send_request(mk_req(OP_INS_RANGE,  $urandom, $urandom, 6'd0,  8'h79, 1'b0));

        write_default(1'b1);
        run_items(280, 80);
        write_default(1'b0);
        run_items(280, 80);

        wait_idle();
        repeat (DRAIN_TAIL) @(negedge clk);

        $display("Drove %0d requests across deny and allow defaults; %0d results checked, %0d hits.",
                 items_sent, checked, hits);
        $display("Table went from empty to full (%0d entries), with rejected and overflow inserts.",
                 entries);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
